>>> sv/mcs_pkg.sv
`timescale 1ns / 1ps

package mcs_pkg;

	localparam int unsigned KEY_W      = 36;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned NSLOT      = 5;
	localparam int unsigned NCAND      = 4;
	localparam int unsigned SLOT_CNT_W = 3;

	localparam logic [KEY_W-1:0] KEY_RESET = 36'h987654321;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	// Morse symbol codes; a symbol pair (row, col) selects key digit row*3+col.
	localparam logic [1:0] SYM_DOT  = 2'd0;
	localparam logic [1:0] SYM_DASH = 2'd1;
	localparam logic [1:0] SYM_SEP  = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 1'b0,
		REG_KEY  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_ERR  = 2'd1,
		KIND_SUM  = 2'd2
	} kind_t;

	// Symbol k of a code sits in bit k, dash is 1.
	typedef struct packed {
		logic [2:0] len;
		logic [4:0] bits;
	} morse_t;

	typedef struct packed {
		logic       found;
		logic [7:0] ch;
	} lookup_t;

	// One candidate result before it is placed in the output buffer.
	typedef struct packed {
		logic       v;
		kind_t      kind;
		logic [7:0] ch;
	} ev_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  char_out;
		logic [15:0] error_count;
		logic        last;
	} res_t;

	typedef struct packed {
		logic       pend_v;
		logic [1:0] pend_sym;
		logic       letter_seen;
	} enc_state_t;

	typedef struct packed {
		logic [4:0] bits;
		logic [2:0] len;
		logic       ovf;
	} dec_state_t;

	// Letters A..Z come first, then digits 0..9.
	function automatic morse_t morse_code(logic [5:0] idx);
		morse_t m;
		unique case (idx)
			6'd0:  m = '{3'd2, 5'b00010};
			6'd1:  m = '{3'd4, 5'b00001};
			6'd2:  m = '{3'd4, 5'b00101};
			6'd3:  m = '{3'd3, 5'b00001};
			6'd4:  m = '{3'd1, 5'b00000};
			6'd5:  m = '{3'd4, 5'b00100};
			6'd6:  m = '{3'd3, 5'b00011};
			6'd7:  m = '{3'd4, 5'b00000};
			6'd8:  m = '{3'd2, 5'b00000};
			6'd9:  m = '{3'd4, 5'b01110};
			6'd10: m = '{3'd3, 5'b00101};
			6'd11: m = '{3'd4, 5'b00010};
			6'd12: m = '{3'd2, 5'b00011};
			6'd13: m = '{3'd2, 5'b00001};
			6'd14: m = '{3'd3, 5'b00111};
			6'd15: m = '{3'd4, 5'b00110};
			6'd16: m = '{3'd4, 5'b01011};
			6'd17: m = '{3'd3, 5'b00010};
			6'd18: m = '{3'd3, 5'b00000};
			6'd19: m = '{3'd1, 5'b00001};
			6'd20: m = '{3'd3, 5'b00100};
			6'd21: m = '{3'd4, 5'b01000};
			6'd22: m = '{3'd3, 5'b00110};
			6'd23: m = '{3'd4, 5'b01001};
			6'd24: m = '{3'd4, 5'b01101};
			6'd25: m = '{3'd4, 5'b00011};
			6'd26: m = '{3'd5, 5'b11111};
			6'd27: m = '{3'd5, 5'b11110};
			6'd28: m = '{3'd5, 5'b11100};
			6'd29: m = '{3'd5, 5'b11000};
			6'd30: m = '{3'd5, 5'b10000};
			6'd31: m = '{3'd5, 5'b00000};
			6'd32: m = '{3'd5, 5'b00001};
			6'd33: m = '{3'd5, 5'b00011};
			6'd34: m = '{3'd5, 5'b00111};
			6'd35: m = '{3'd5, 5'b01111};
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] morse_char(logic [5:0] idx);
		logic [7:0] c;
		if (idx < 6'd26) begin
			c = 8'h41 + {2'b00, idx};
		end else begin
			c = 8'h30 + ({2'b00, idx} - 8'd26);
		end
		return c;
	endfunction

	// Codes are unique, so every entry is compared in parallel.
	function automatic lookup_t morse_lookup(morse_t code);
		lookup_t r;
		r = '0;
		for (int i = 0; i < 36; i++) begin
			if (!r.found && morse_code(6'(i)) == code) begin
				r.found = 1'b1;
				r.ch    = morse_char(6'(i));
			end
		end
		return r;
	endfunction

	function automatic logic [3:0] key_nibble(logic [KEY_W-1:0] key, logic [3:0] pos);
		logic [3:0] p;
		p = (pos > 4'd8) ? 4'd8 : pos;
		return key[{p, 2'b00} +: 4];
	endfunction

endpackage

>>> sv/mcs_if.sv
`timescale 1ns / 1ps

interface mcs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_message;

	modport source (output valid, output char_code, output end_of_message, input ready);
	modport sink (input valid, input char_code, input end_of_message, output ready);
endinterface

interface mcs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  char_out;
	logic [15:0] error_count;
	logic        last;

	modport source (output valid, output kind, output char_out, output error_count,
		output last, input ready);
	modport sink (input valid, input kind, input char_out, input error_count,
		input last, output ready);
endinterface

>>> sv/mcs_enc.sv
`timescale 1ns / 1ps

module mcs_enc (
	input  logic [7:0]                char_code,
	input  logic                      eom,
	input  logic [mcs_pkg::KEY_W-1:0] key,
	input  mcs_pkg::enc_state_t       st,
	output mcs_pkg::ev_t [mcs_pkg::NCAND-1:0] ev,
	output mcs_pkg::enc_state_t       st_next
);
	import mcs_pkg::*;

	logic [7:0]  c;
	logic        idx_v;
	logic [5:0]  idx;
	morse_t      mc;
	logic [2:0]  len_eff;
	logic [9:0]  mv;
	logic        sep_v;
	logic [1:0]  h;
	logic [3:0]  head;
	logic [15:0] seq;
	logic [3:0]  n;
	logic [2:0]  last_idx;
	logic [1:0]  row;
	logic [1:0]  col;
	logic [3:0]  pos;

	always_comb begin
		c = char_code;
		if (c >= 8'h61 && c <= 8'h7A) begin
			c = c - 8'h20;
		end
		idx_v = 1'b0;
		idx   = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			idx_v = 1'b1;
			idx   = 6'(c - 8'h41);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			idx_v = 1'b1;
			idx   = 6'(c - 8'h30) + 6'd26;
		end
		mc      = morse_code(idx);
		len_eff = idx_v ? mc.len : 3'd0;
		for (int k = 0; k < 5; k++) begin
			mv[2*k +: 2] = {1'b0, mc.bits[k]};
		end

		// Symbol stream: waiting odd symbol, separator, then the new code.
		sep_v = idx_v && st.letter_seen;
		h     = {1'b0, st.pend_v} + {1'b0, sep_v};
		head  = '0;
		if (st.pend_v) begin
			head[1:0] = st.pend_sym;
		end
		if (sep_v) begin
			if (st.pend_v) begin
				head[3:2] = SYM_SEP;
			end else begin
				head[1:0] = SYM_SEP;
			end
		end
		seq = ({6'b0, mv} << {h, 1'b0}) | {12'b0, head};
		n   = {2'b00, h} + {1'b0, len_eff};
		if (eom && n[0]) begin
			seq = seq | (16'(SYM_SEP) << {n, 1'b0});
			n   = n + 4'd1;
		end

		for (int p = 0; p < NCAND; p++) begin
			row        = seq[4*p +: 2];
			col        = seq[4*p+2 +: 2];
			pos        = {2'b00, row} * 4'd3 + {2'b00, col};
			ev[p].v    = (n[3:1] > 3'(p));
			ev[p].kind = KIND_CHAR;
			ev[p].ch   = 8'h30 + {4'b0000, key_nibble(key, pos)};
		end

		last_idx            = n[2:0] - 3'd1;
		st_next.pend_v      = n[0];
		st_next.pend_sym    = n[0] ? seq[{last_idx, 1'b0} +: 2] : SYM_DOT;
		st_next.letter_seen = st.letter_seen | idx_v;
	end

endmodule

>>> sv/mcs_dec.sv
`timescale 1ns / 1ps

module mcs_dec (
	input  logic [7:0]                char_code,
	input  logic                      eom,
	input  logic [mcs_pkg::KEY_W-1:0] key,
	input  mcs_pkg::dec_state_t       st,
	output mcs_pkg::ev_t [mcs_pkg::NCAND-1:0] ev,
	output mcs_pkg::dec_state_t       st_next
);
	import mcs_pkg::*;

	typedef struct packed {
		dec_state_t st;
		ev_t        ev;
	} push_t;

	function automatic ev_t dec_finish(dec_state_t s);
		ev_t     r;
		lookup_t lk;
		r  = '0;
		lk = morse_lookup(morse_t'{s.len, s.bits});
		r.v = (s.len != 3'd0) || s.ovf;
		if (s.ovf || !lk.found) begin
			r.kind = KIND_ERR;
		end else begin
			r.kind = KIND_CHAR;
			r.ch   = lk.ch;
		end
		return r;
	endfunction

	function automatic push_t dec_push(dec_state_t s, logic [1:0] sym);
		push_t r;
		r.st = s;
		r.ev = '0;
		if (sym == SYM_SEP) begin
			r.ev = dec_finish(s);
			r.st = '0;
		end else if (s.len < 3'd5) begin
			r.st.bits[s.len] = sym[0];
			r.st.len         = s.len + 3'd1;
		end else begin
			r.st.ovf = 1'b1;
		end
		return r;
	endfunction

	// Key position to symbol pair {row, col}.
	function automatic logic [3:0] pos_pair(logic [3:0] pos);
		logic [3:0] rc;
		unique case (pos)
			4'd0: rc = {SYM_DOT,  SYM_DOT};
			4'd1: rc = {SYM_DOT,  SYM_DASH};
			4'd2: rc = {SYM_DOT,  SYM_SEP};
			4'd3: rc = {SYM_DASH, SYM_DOT};
			4'd4: rc = {SYM_DASH, SYM_DASH};
			4'd5: rc = {SYM_DASH, SYM_SEP};
			4'd6: rc = {SYM_SEP,  SYM_DOT};
			4'd7: rc = {SYM_SEP,  SYM_DASH};
			4'd8: rc = {SYM_SEP,  SYM_SEP};
			default: rc = {SYM_DOT, SYM_DOT};
		endcase
		return rc;
	endfunction

	logic       dig;
	logic [3:0] d;
	logic       found;
	logic [3:0] pos;
	logic       bad;
	logic [3:0] rc;
	push_t      p1;
	push_t      p2;
	dec_state_t st2;

	always_comb begin
		dig   = (char_code >= 8'h31) && (char_code <= 8'h39);
		d     = char_code[3:0];
		found = 1'b0;
		pos   = '0;
		// The highest key position holding the digit wins.
		for (int i = 0; i < 9; i++) begin
			if (key[4*i +: 4] == d) begin
				found = 1'b1;
				pos   = 4'(i);
			end
		end
		bad = !dig || !found;
		rc  = pos_pair(pos);
		p1  = dec_push(st, rc[3:2]);
		p2  = dec_push(p1.st, rc[1:0]);

		ev[0] = '0;
		if (bad) begin
			ev[0].v    = 1'b1;
			ev[0].kind = KIND_ERR;
			ev[1]      = '0;
			ev[2]      = '0;
			st2        = st;
		end else begin
			ev[1] = p1.ev;
			ev[2] = p2.ev;
			st2   = p2.st;
		end
		ev[3]   = eom ? dec_finish(st2) : '0;
		st_next = st2;
	end

endmodule

>>> sv/mcs_obuf.sv
`timescale 1ns / 1ps

module mcs_obuf (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  mcs_pkg::res_t [mcs_pkg::NSLOT-1:0]    load_slots,
	input  logic [mcs_pkg::SLOT_CNT_W-1:0]        load_cnt,
	output logic                                  free,
	mcs_out_if.source                             res_out
);
	import mcs_pkg::*;

	res_t [NSLOT-1:0]      slots_q;
	logic [SLOT_CNT_W-1:0] cnt_q;
	logic                  take;

	assign take = res_out.valid && res_out.ready;
	// The buffer can take a new set when it is empty or its final word leaves now.
	assign free = (cnt_q == '0) || (cnt_q == SLOT_CNT_W'(1) && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (take) begin
			cnt_q <= cnt_q - SLOT_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slots_q <= load_slots;
		end else if (take) begin
			for (int i = 0; i < NSLOT - 1; i++) begin
				slots_q[i] <= slots_q[i+1];
			end
		end
	end

	assign res_out.valid       = (cnt_q != '0);
	assign res_out.kind        = slots_q[0].kind;
	assign res_out.char_out    = slots_q[0].char_out;
	assign res_out.error_count = slots_q[0].error_count;
	assign res_out.last        = slots_q[0].last;

	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.last |-> cnt_q == SLOT_CNT_W'(1))
		else $error("summary word is not the final word of its set");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		take && cnt_q == SLOT_CNT_W'(1) && !load |=> !res_out.valid)
		else $error("buffer still valid after its final word left");

endmodule

>>> sv/morbit_cipher_stream.sv
`timescale 1ns / 1ps

// Streaming Morbit cipher.
// char_in carries one ASCII character per word, with end_of_message on the
// final character of a message. res_out carries result words: a cipher digit
// or decoded character, a decode error, or the end-of-message summary, which
// has last set and the message error count. The cfg port writes the mode
// (0 encrypt, 1 decrypt) and the 36-bit key; write it only while idle.
// An accepted word waits in the input register until the result buffer is
// free; then all of its results are computed at once and registered into
// the five-entry result buffer, whose head is the result word presented.
// A new word is accepted every cycle while results fit: a word that causes
// k results holds the result buffer until all k are taken, so an encrypted
// letter (up to four digits plus a summary) may fill all five, and the output
// channel sets the sustained rate. When the receiver stalls, the buffer and
// then the input register fill and char_in.ready falls; nothing is lost.
// Reset clears all message state, sets mode to encrypt and loads the key
// 123456789. There is no clearing pass.
module morbit_cipher_stream (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mcs_pkg::KEY_W-1:0]     cfg_wdata,
	mcs_in_if.sink                        char_in,
	mcs_out_if.source                     res_out
);
	import mcs_pkg::*;

	// Configuration registers.
	logic             mode_q;
	logic [KEY_W-1:0] key_q;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eom_s1;

	// Message state kept between words.
	enc_state_t  enc_q;
	dec_state_t  dec_q;
	logic [15:0] errors_q;

	ev_t [NCAND-1:0]       enc_ev;
	ev_t [NCAND-1:0]       dec_ev;
	enc_state_t            enc_next;
	dec_state_t            dec_next;
	ev_t [NCAND:0]         cand;
	res_t [NSLOT-1:0]      slots;
	logic [SLOT_CNT_W-1:0] n;
	logic [2:0]            errk;
	logic [16:0]           sum;
	logic [15:0]           errors_next;
	logic                  buf_free;
	logic                  load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
			key_q  <= KEY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_MODE: mode_q <= cfg_wdata[0];
				REG_KEY:  key_q  <= cfg_wdata;
			endcase
		end
	end

	// A word moves from the input register to the result buffer whenever the
	// buffer is free, so the input register can refill in the same cycle.
	assign load          = valid_s1 && buf_free;
	assign char_in.ready = !valid_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && char_in.ready) begin
			char_s1 <= char_in.char_code;
			eom_s1  <= char_in.end_of_message;
		end
	end

	mcs_enc u_enc (
		.char_code (char_s1),
		.eom       (eom_s1),
		.key       (key_q),
		.st        (enc_q),
		.ev        (enc_ev),
		.st_next   (enc_next)
	);

	mcs_dec u_dec (
		.char_code (char_s1),
		.eom       (eom_s1),
		.key       (key_q),
		.st        (dec_q),
		.ev        (dec_ev),
		.st_next   (dec_next)
	);

	// Pack the valid candidates into consecutive buffer slots. Each result
	// carries the error count after itself, saturating at all ones.
	always_comb begin
		cand[NCAND-1:0]   = (mode_q == MODE_DEC) ? dec_ev : enc_ev;
		cand[NCAND].v     = eom_s1;
		cand[NCAND].kind  = KIND_SUM;
		cand[NCAND].ch    = 8'h00;
		slots = '0;
		n     = '0;
		errk  = '0;
		sum   = {1'b0, errors_q};
		for (int i = 0; i <= NCAND; i++) begin
			if (cand[i].v) begin
				if (cand[i].kind == KIND_ERR) begin
					errk = errk + 3'd1;
				end
				sum = {1'b0, errors_q} + 17'(errk);
				slots[n].kind        = cand[i].kind;
				slots[n].char_out    = cand[i].ch;
				slots[n].error_count = sum[16] ? 16'hFFFF : sum[15:0];
				slots[n].last        = (i == NCAND);
				n = n + SLOT_CNT_W'(1);
			end
		end
		errors_next = sum[16] ? 16'hFFFF : sum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q    <= '0;
			dec_q    <= '0;
			errors_q <= '0;
		end else if (load) begin
			if (eom_s1) begin
				enc_q    <= '0;
				dec_q    <= '0;
				errors_q <= '0;
			end else begin
				errors_q <= errors_next;
				if (mode_q == MODE_DEC) begin
					dec_q <= dec_next;
				end else begin
					enc_q <= enc_next;
				end
			end
		end
	end

	mcs_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_slots (slots),
		.load_cnt   (n),
		.free       (buf_free),
		.res_out    (res_out)
	);

	a_eom_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load && eom_s1 |=> errors_q == '0 && !enc_q.pend_v && !enc_q.letter_seen
			&& dec_q.len == '0 && !dec_q.ovf)
		else $error("message state not cleared after end of message");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		dec_q.ovf |-> dec_q.len == 3'd5)
		else $error("code overflow flagged before five symbols");

	a_pend_sym: assert property (@(posedge clk) disable iff (!arst_n)
		enc_q.pend_v |-> enc_q.pend_sym == SYM_DOT || enc_q.pend_sym == SYM_DASH
			|| enc_q.pend_sym == SYM_SEP)
		else $error("pending symbol holds no symbol code");

endmodule

>>> tb/tb_morbit_cipher_stream.sv
`timescale 1ns / 1ps

module tb_morbit_cipher_stream;
	import mcs_pkg::*;

	// A stall of this many cycles with no word moving on either channel means
	// the block has hung. In a correct run the longest quiet stretch is one
	// sender gap or one receiver stall.
	localparam int WATCHDOG_LIMIT = 4000;
	// Words that produce no result may still be in flight when the last
	// expected result arrives; such a word still passes through the input
	// register, and this margin lets it leave before any register is touched.
	localparam int SETTLE_CYCLES = 8;
	// A short run of bad cipher digits in one message, sent at full speed.
	localparam int BAD_RUN = 12;
	localparam int RANDOM_ITEMS = 240;

	localparam logic [KEY_W-1:0] KEY_ZERO   = '0;
	localparam logic [KEY_W-1:0] KEY_ONES   = '1;
	localparam logic [KEY_W-1:0] KEY_REPEAT = 36'h111111111;

	localparam string ALNUM =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";

	typedef struct packed {
		logic [7:0] ch;
		logic       eom;
	} char_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [KEY_W-1:0] cfg_wdata;

	mcs_in_if  char_if ();
	mcs_out_if result_if ();

	morbit_cipher_stream dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.char_in  (char_if),
		.res_out  (result_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Morse codes of A..Z and then 0..9, written as dots and dashes.
	string morse_text [36] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
		"---..", "----."
	};

	// Shadow copy of the configuration and of the per-message cipher state.
	logic             mdl_mode;
	logic [KEY_W-1:0] mdl_key;
	logic             pend_v;
	logic [1:0]       pend_sym;
	logic             letter_seen;
	logic [4:0]       code_bits;
	logic [2:0]       code_len;
	logic             code_ovf;
	logic [15:0]      mdl_errs;
	int               step_results;

	char_word_t char_words [$];      // characters still to be offered
	res_t       awaited_results [$]; // predicted result words, oldest first

	int  words_queued = 0;
	int  words_taken = 0;
	int  random_items = 0;
	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  send_gap = 0;
	int  hold_off = 0;
	bit  idle_on = 1'b1;
	logic in_fire = 1'b0;

	// ------------------------------------------------------------------
	// Cipher predictor
	// ------------------------------------------------------------------

	function automatic logic [3:0] key_at(int pos);
		return mdl_key[pos*4 +: 4];
	endfunction

	// The block never produces more than five result words for one character.
	task automatic emit(kind_t k, logic [7:0] c, logic l);
		if (step_results < NSLOT) begin
			awaited_results.push_back('{kind: k, char_out: c, error_count: mdl_errs, last: l});
			step_results++;
		end
	endtask

	task automatic emit_error();
		if (mdl_errs != 16'hFFFF) mdl_errs++;
		emit(KIND_ERR, 8'h00, 1'b0);
	endtask

	// Symbols pair up; the first of a pair picks the key row, the second the column.
	task automatic encode_symbol(logic [1:0] s);
		if (pend_v) begin
			emit(KIND_CHAR, 8'h30 + key_at(int'(pend_sym) * 3 + int'(s)), 1'b0);
			pend_v = 1'b0;
			pend_sym = SYM_DOT;
		end else begin
			pend_sym = s;
			pend_v = 1'b1;
		end
	endtask

	// Close the letter being collected and look its code up.
	task automatic close_letter();
		int    found;
		bit    ok;
		string m;
		if (code_len == 0 && !code_ovf) return;
		if (code_ovf) begin
			emit_error();
		end else begin
			found = -1;
			for (int i = 0; i < 36; i++) begin
				m = morse_text[i];
				ok = (m.len() == int'(code_len));
				for (int k = 0; k < m.len() && ok; k++)
					if ((m[k] == "-") != code_bits[k]) ok = 1'b0;
				if (ok && found < 0) found = i;
			end
			if (found < 0) emit_error();
			else if (found < 26) emit(KIND_CHAR, 8'(65 + found), 1'b0);
			else emit(KIND_CHAR, 8'(48 + found - 26), 1'b0);
		end
		code_bits = '0;
		code_len = '0;
		code_ovf = 1'b0;
	endtask

	task automatic decode_symbol(logic [1:0] s);
		if (s == SYM_SEP) begin
			close_letter();
		end else if (code_len < 5) begin
			code_bits[code_len] = s[0];
			code_len++;
		end else begin
			code_ovf = 1'b1;
		end
	endtask

	// Works out every result word that one accepted character causes.
	task automatic morbit_predict(logic [7:0] c, logic eom);
		int    idx;
		int    pos;
		string m;
		step_results = 0;
		if (mdl_mode == MODE_ENC) begin
			idx = -1;
			if (c >= "a" && c <= "z") c = c - 8'd32;
			if (c >= "A" && c <= "Z") idx = int'(c) - 65;
			else if (c >= "0" && c <= "9") idx = 26 + int'(c) - 48;
			if (idx >= 0) begin
				m = morse_text[idx];
				if (letter_seen) encode_symbol(SYM_SEP);
				for (int k = 0; k < m.len(); k++)
					encode_symbol(m[k] == "-" ? SYM_DASH : SYM_DOT);
				letter_seen = 1'b1;
			end
			if (eom && pend_v) encode_symbol(SYM_SEP);
		end else begin
			if (c >= "1" && c <= "9") begin
				// A digit held at several key positions decodes to the highest one.
				pos = -1;
				for (int i = 0; i < 9; i++)
					if (key_at(i) == 4'(c - 8'h30)) pos = i;
				if (pos < 0) begin
					emit_error();
				end else begin
					decode_symbol(2'(pos / 3));
					decode_symbol(2'(pos % 3));
				end
			end else begin
				emit_error();
			end
			if (eom) close_letter();
		end
		if (eom) begin
			emit(KIND_SUM, 8'h00, 1'b1);
			pend_v = 1'b0;
			pend_sym = SYM_DOT;
			letter_seen = 1'b0;
			code_bits = '0;
			code_len = '0;
			code_ovf = 1'b0;
			mdl_errs = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// Channel activity
	// ------------------------------------------------------------------

	// Gap lengths: usually none, often a short one, now and then a long one.
	function automatic int idle_len();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Character driver. A word stays on the channel until it is taken, then
	// the next one follows after a random gap.
	always @(negedge clk) begin
		char_word_t w;
		if (arst_n) begin
			if (!char_if.valid || in_fire) begin
				if (send_gap != 0) begin
					char_if.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (char_words.size() != 0) begin
					w = char_words.pop_front();
					char_if.valid <= 1'b1;
					char_if.char_code <= w.ch;
					char_if.end_of_message <= w.eom;
					send_gap <= idle_len();
				end else begin
					char_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver back-pressure.
	always @(negedge clk) begin
		int n;
		if (arst_n) begin
			if (hold_off != 0) begin
				result_if.ready <= 1'b0;
				hold_off <= hold_off - 1;
			end else begin
				n = idle_len();
				if (n == 0) begin
					result_if.ready <= 1'b1;
				end else begin
					result_if.ready <= 1'b0;
					hold_off <= n - 1;
				end
			end
		end
	end

	// Monitor: every accepted character feeds the predictor, and every
	// accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			in_fire <= char_if.valid && char_if.ready;
			if (char_if.valid && char_if.ready) begin
				morbit_predict(char_if.char_code, char_if.end_of_message);
				words_taken++;
			end
			if (result_if.valid && result_if.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result word with no prediction: kind %0d char %0h count %0d last %0d",
						result_if.kind, result_if.char_out, result_if.error_count, result_if.last);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (want.kind !== result_if.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result_if.kind);
						mismatches++;
					end
					if (want.char_out !== result_if.char_out) begin
						$error("char_out: expected %0h, got %0h", want.char_out, result_if.char_out);
						mismatches++;
					end
					if (want.error_count !== result_if.error_count) begin
						$error("error_count: expected %0d, got %0d", want.error_count,
							result_if.error_count);
						mismatches++;
					end
					if (want.last !== result_if.last) begin
						$error("last: expected %0d, got %0d", want.last, result_if.last);
						mismatches++;
					end
				end
			end
			if ((char_if.valid && char_if.ready) || (result_if.valid && result_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Watchdog: the run is given up once nothing has moved for too long.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic send(logic [7:0] c, logic eom);
		char_words.push_back('{ch: c, eom: eom});
		words_queued++;
	endtask

	// Waits until every character was taken and every result came back,
	// then lets the pipeline drain words that produce nothing.
	task automatic settle();
		do @(negedge clk); while (words_taken != words_queued || awaited_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register writes only happen while the block is idle, so the shadow copy
	// can follow right away.
	task automatic write_reg(cfg_reg_t idx, logic [KEY_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MODE) mdl_mode = value[0];
		else mdl_key = value;
	endtask

	// Mostly a shuffled 1..9 key, sometimes one with a repeated digit, and
	// sometimes 36 arbitrary bits that may hold nibbles above 9.
	function automatic logic [KEY_W-1:0] random_key();
		logic [3:0]       d [9];
		logic [3:0]       t;
		logic [KEY_W-1:0] k;
		int               j;
		int               r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			k = KEY_W'({$urandom, $urandom});
			return k;
		end
		for (int i = 0; i < 9; i++) d[i] = 4'(i + 1);
		for (int i = 8; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = d[i];
			d[i] = d[j];
			d[j] = t;
		end
		if (r < 30) d[$urandom_range(0, 8)] = d[$urandom_range(0, 8)];
		for (int i = 0; i < 9; i++) k[i*4 +: 4] = d[i];
		return k;
	endfunction

	// Plaintext: mostly letters and digits in both cases, some arbitrary bytes.
	task automatic send_plaintext(int n, bit close);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 75) begin
				c = ALNUM[$urandom_range(0, 61)];
			end else begin
				c = 8'($urandom_range(0, 255));
			end
			send(c, close && i == n - 1);
			random_items++;
		end
	endtask

	// Ciphertext built from real Morse letters under the current key, with
	// the odd made-up code and the odd garbage character mixed in.
	task automatic send_ciphertext(int letters, bit close);
		logic [1:0] syms [$];
		logic [7:0] c;
		string      m;
		int         n;
		for (int l = 0; l < letters; l++) begin
			if (l > 0) syms.push_back(SYM_SEP);
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 7);
				repeat (n) syms.push_back($urandom_range(0, 1) ? SYM_DASH : SYM_DOT);
			end else begin
				m = morse_text[$urandom_range(0, 35)];
				for (int k = 0; k < m.len(); k++)
					syms.push_back(m[k] == "-" ? SYM_DASH : SYM_DOT);
			end
		end
		if (syms.size() % 2 != 0) syms.push_back(SYM_SEP);
		for (int k = 0; k < syms.size(); k += 2) begin
			c = 8'h30 + key_at(int'(syms[k]) * 3 + int'(syms[k+1]));
			if ($urandom_range(0, 19) == 0) c = 8'($urandom_range(0, 255));
			send(c, close && k + 2 >= syms.size());
			random_items++;
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		bit close;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MODE;
		cfg_wdata = '0;
		char_if.valid = 1'b0;
		char_if.char_code = '0;
		char_if.end_of_message = 1'b0;
		result_if.ready = 1'b0;
		mdl_mode = MODE_ENC;
		mdl_key = KEY_RESET;
		pend_v = 1'b0;
		pend_sym = SYM_DOT;
		letter_seen = 1'b0;
		code_bits = '0;
		code_len = '0;
		code_ovf = 1'b0;
		mdl_errs = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Encryption with the reset key: case folding, letters and digits at
		// both ends of the range, a skipped punctuation mark, and a message
		// closed by a non-alphanumeric word that still pads the odd symbol.
		send("a", 1'b0);
		send("Z", 1'b0);
		send("0", 1'b0);
		send("9", 1'b0);
		send("!", 1'b0);
		send(8'h00, 1'b1);
		// A message that is nothing but an ignored word still ends in a summary.
		send(8'hFF, 1'b1);
		settle();

		// Key extremes: all-zero nibbles, then nibbles above 9.
		write_reg(REG_KEY, KEY_ZERO);
		send("E", 1'b1);
		settle();
		write_reg(REG_KEY, KEY_ONES);
		send("5", 1'b1);
		settle();

		// Decryption with the reset key, where digit d stands for position d-1.
		write_reg(REG_KEY, KEY_RESET);
		write_reg(REG_MODE, KEY_W'(MODE_DEC));
		send("1", 1'b0);             // dot dot
		send("3", 1'b0);             // dot, letter break: S
		send("5", 1'b0);             // dash dash
		send("9", 1'b0);             // two breaks: M, then an empty letter
		send("1", 1'b0);
		send("1", 1'b0);
		send("1", 1'b0);
		send("3", 1'b0);             // seven dots overflow the letter
		send("1", 1'b0);
		send("5", 1'b0);
		send("9", 1'b0);             // dot dot dash dash is no letter
		send("0", 1'b0);             // not a cipher digit
		send(8'h3A, 1'b0);
		send(8'hFF, 1'b0);
		send("4", 1'b1);             // dash dot closed by the message end: N
		settle();

		// A key with every digit the same: only the top position decodes,
		// and every other digit is unknown.
		write_reg(REG_KEY, KEY_REPEAT);
		send("1", 1'b0);
		send("2", 1'b1);
		settle();

		// Run of bad digits at full speed, so error words follow back to back.
		idle_on = 1'b0;
		write_reg(REG_KEY, KEY_RESET);
		repeat (BAD_RUN) send("0", 1'b0);
		send("?", 1'b1);
		settle();

		// Random messages under changing keys and modes. Some messages are
		// left open so that a later mode switch meets state in flight.
		while (random_items < RANDOM_ITEMS) begin
			settle();
			idle_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 1)) write_reg(REG_KEY, random_key());
			if ($urandom_range(0, 2) != 0) write_reg(REG_MODE, KEY_W'($urandom_range(0, 1)));
			close = ($urandom_range(0, 9) < 7);
			if (mdl_mode == MODE_ENC) send_plaintext($urandom_range(1, 16), close);
			else send_ciphertext($urandom_range(1, 8), close);
		end

		settle();
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
